/* rtl/position_moving_average_unit_macros.svh */
// Assertion macros for the position moving average unit.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef POSITION_MOVING_AVERAGE_UNIT_MACROS_SVH
`define POSITION_MOVING_AVERAGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PMA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("position moving average: same-cycle check failed");
`define PMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("position moving average: next-cycle check failed");
`else
`define PMA_ASSERT(label, ante, cons)
`define PMA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/pma_pkg.sv */
// Shared constants and controller/datapath interface types for the
// position moving average unit. No dependencies.
package pma_pkg;

  localparam int unsigned MaxWindowDef = 255;
  localparam int unsigned PosWidthDef  = 32;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned WinW         = 8;
  localparam logic [WinW-1:0] WindowReset = 8'd4;

  typedef struct packed {
    logic capture;
    logic fill_wr;
    logic ring_wr;
    logic acc_rd;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_paused;
    logic in_refill;
    logic fill_last;
    logic rd_last;
    logic div_last;
  } sts_t;

endpackage

/* rtl/pma_ctrl.sv */
// Sequencing state machine of the position moving average unit.
// Depends on pma_pkg for the command and status types.
module pma_ctrl import pma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_RING   = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.in_paused) begin
            state_d = S_RESULT;
          end else if (sts_i.in_refill) begin
            state_d = S_FILL;
          end else begin
            state_d = S_RING;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_RESULT;
        end
      end
      S_RING: begin
        cmd_o.ring_wr = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_rd = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/pma_datapath.sv */
// History memory, accumulators, bit-serial divider and output registers of
// the position moving average unit. Depends on pma_pkg.
module pma_datapath import pma_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef,
  parameter int unsigned POS_WIDTH  = PosWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [WinW-1:0]             cfg_wr_data_i,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic                        paused_i,
  input  logic                        restart_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic signed [POS_WIDTH-1:0] avg_x_o,
  output logic signed [POS_WIDTH-1:0] avg_y_o,
  output logic signed [POS_WIDTH-1:0] avg_z_o
);

  localparam int unsigned PtrW  = $clog2(MAX_WINDOW);
  localparam int unsigned SumW  = POS_WIDTH + $clog2(MAX_WINDOW + 1);
  localparam int unsigned DcntW = $clog2(SumW);
  localparam int unsigned WordW = NumAxes * POS_WIDTH;

  logic [WordW-1:0]          hist_mem [MAX_WINDOW];
  logic [WordW-1:0]          rd_data_q;
  logic                      rd_vld_q;
  logic                      wr_en;
  logic [PtrW-1:0]           wr_addr;

  logic [WinW-1:0]           window_length_q;
  logic [WinW-1:0]           n_eff;
  logic [WinW-1:0]           n_q;
  logic                      primed_q;
  logic [PtrW-1:0]           ptr_q;
  logic [PtrW-1:0]           fill_addr_q;
  logic [PtrW-1:0]           rd_addr_q;
  logic [WinW-1:0]           rd_cnt_q;
  logic [DcntW-1:0]          div_cnt_q;
  logic                      pass_q;

  logic [POS_WIDTH-1:0]      pos_q   [NumAxes];
  logic signed [SumW-1:0]    sum_q   [NumAxes];
  logic [SumW-1:0]           quo_q   [NumAxes];
  logic [WinW-1:0]           rem_q   [NumAxes];
  logic                      neg_q   [NumAxes];
  logic [POS_WIDTH-1:0]      avg_q   [NumAxes];
  logic [WinW:0]             rem_sh  [NumAxes];
  logic                      ge      [NumAxes];
  logic [WinW-1:0]           rem_nx  [NumAxes];
  logic [POS_WIDTH-1:0]      res     [NumAxes];
  logic [POS_WIDTH-1:0]      rd_pos  [NumAxes];
  logic [WordW-1:0]          wr_word;

  always_comb begin
    if (window_length_q == '0) begin
      n_eff = WinW'(1);
    end else if (window_length_q > WinW'(MAX_WINDOW)) begin
      n_eff = WinW'(MAX_WINDOW);
    end else begin
      n_eff = window_length_q;
    end
  end

  assign wr_en   = cmd_i.fill_wr || cmd_i.ring_wr;
  assign wr_addr = cmd_i.fill_wr ? fill_addr_q : ptr_q;
  assign wr_word = {pos_q[2], pos_q[1], pos_q[0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_word;
    end
    if (cmd_i.acc_rd) begin
      rd_data_q <= hist_mem[rd_addr_q];
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      rd_pos[a] = rd_data_q[a*POS_WIDTH +: POS_WIDTH];
      rem_sh[a] = {rem_q[a], quo_q[a][SumW-1]};
      ge[a]     = (rem_sh[a] >= {1'b0, n_q});
      rem_nx[a] = ge[a] ? WinW'(rem_sh[a] - {1'b0, n_q}) : rem_sh[a][WinW-1:0];
      res[a]    = neg_q[a] ? POS_WIDTH'(-quo_q[a][POS_WIDTH-1:0])
                           : quo_q[a][POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WindowReset;
      primed_q        <= 1'b0;
      ptr_q           <= '0;
      rd_vld_q        <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        window_length_q <= cfg_wr_data_i;
      end
      if (cmd_i.fill_wr && sts_o.fill_last) begin
        primed_q <= 1'b1;
        ptr_q    <= '0;
      end else if (cmd_i.ring_wr) begin
        ptr_q <= (ptr_q == PtrW'(MAX_WINDOW - 1)) ? '0 : ptr_q + PtrW'(1);
      end
      rd_vld_q <= cmd_i.acc_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q[0]    <= pos_x_i;
      pos_q[1]    <= pos_y_i;
      pos_q[2]    <= pos_z_i;
      pass_q      <= paused_i || sts_o.in_refill;
      fill_addr_q <= '0;
    end
    if (cmd_i.fill_wr) begin
      fill_addr_q <= fill_addr_q + PtrW'(1);
    end
    if (cmd_i.ring_wr) begin
      rd_addr_q <= ptr_q;
      rd_cnt_q  <= '0;
      n_q       <= n_eff;
    end
    if (cmd_i.acc_rd) begin
      rd_addr_q <= (rd_addr_q == '0) ? PtrW'(MAX_WINDOW - 1) : rd_addr_q - PtrW'(1);
      rd_cnt_q  <= rd_cnt_q + WinW'(1);
    end
    if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DcntW'(1);
    end
    for (int a = 0; a < NumAxes; a++) begin
      if (cmd_i.ring_wr) begin
        sum_q[a] <= '0;
      end else if (rd_vld_q) begin
        sum_q[a] <= sum_q[a] + {{(SumW-POS_WIDTH){rd_pos[a][POS_WIDTH-1]}}, rd_pos[a]};
      end
      if (cmd_i.div_start) begin
        neg_q[a] <= sum_q[a][SumW-1];
        quo_q[a] <= sum_q[a][SumW-1] ? SumW'(-sum_q[a]) : SumW'(sum_q[a]);
        rem_q[a] <= '0;
      end else if (cmd_i.div_step) begin
        quo_q[a] <= {quo_q[a][SumW-2:0], ge[a]};
        rem_q[a] <= rem_nx[a];
      end
      if (cmd_i.load_out) begin
        avg_q[a] <= pass_q ? pos_q[a] : res[a];
      end
    end
  end

  assign sts_o.in_paused = paused_i;
  assign sts_o.in_refill = !primed_q || restart_i;
  assign sts_o.fill_last = (fill_addr_q == PtrW'(MAX_WINDOW - 1));
  assign sts_o.rd_last   = (rd_cnt_q == n_q - WinW'(1));
  assign sts_o.div_last  = (div_cnt_q == DcntW'(SumW - 1));

  assign avg_x_o = avg_q[0];
  assign avg_y_o = avg_q[1];
  assign avg_z_o = avg_q[2];

endmodule

/* rtl/position_moving_average_unit.sv */
// Boxcar smoothing of a 3-D Q16.16 position over the last window_length
// samples. One word is worked on at a time and in_stall_o stays high until
// its result has been placed in the output register, which may still wait
// there while the next word is taken. A paused word goes straight to the
// output register. Else the first word after reset, or one with restart set,
// writes every one of the MAX_WINDOW history entries through the single
// memory write port. Any other word reads the last N history entries, N
// being the effective window (one history read per cycle), and then runs
// the POS_WIDTH + clog2(MAX_WINDOW + 1) steps of the bit-serial divider.
// Depends on pma_pkg.
`include "position_moving_average_unit_macros.svh"
module position_moving_average_unit import pma_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef,
  parameter int unsigned POS_WIDTH  = PosWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [WinW-1:0]             cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic                        paused_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [POS_WIDTH-1:0] avg_x_o,
  output logic signed [POS_WIDTH-1:0] avg_y_o,
  output logic signed [POS_WIDTH-1:0] avg_z_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [4:0] work_cmds;

  pma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pma_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .POS_WIDTH  (POS_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .paused_i      (paused_i),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .avg_x_o       (avg_x_o),
    .avg_y_o       (avg_y_o),
    .avg_z_o       (avg_z_o)
  );

  assign work_cmds = {cmd.fill_wr, cmd.ring_wr, cmd.acc_rd, cmd.div_step, cmd.load_out};

  `PMA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `PMA_ASSERT(a_one_work_cmd, 1'b1, $onehot0(work_cmds))
  `PMA_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid_o)

endmodule

/* dv/position_moving_average_unit_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the position moving average unit: tracks the position history and
// window length itself, predicts each smoothed word and compares it with what comes
// out of the unit. Depends on pma_pkg.
module position_moving_average_unit_checker import pma_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef,
  parameter int unsigned POS_WIDTH  = PosWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [WinW-1:0]      cfg_wr_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [POS_WIDTH-1:0] pos_x_i,
  input  logic [POS_WIDTH-1:0] pos_y_i,
  input  logic [POS_WIDTH-1:0] pos_z_i,
  input  logic                 paused_i,
  input  logic                 restart_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [POS_WIDTH-1:0] avg_x_i,
  input  logic [POS_WIDTH-1:0] avg_y_i,
  input  logic [POS_WIDTH-1:0] avg_z_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned ReportLimit = 100;

  typedef logic [NumAxes-1:0][POS_WIDTH-1:0] position_t;

  position_t       history [MAX_WINDOW];
  position_t       smoothed_queue [$];
  int unsigned     next_slot = 0;
  logic            history_primed = 1'b0;
  logic [WinW-1:0] window_len = WindowReset;
  int unsigned     fail_count = 0;

  task automatic smooth_word(input position_t pos, input logic pause, input logic refill);
    position_t   result;
    longint      axis_sum [NumAxes];
    longint      mean;
    int unsigned n;
    int unsigned k;
    result = pos;
    if (!pause && history_primed && !refill) begin
      history[next_slot] = pos;
      n = (window_len == 0) ? 1 : ((window_len > MAX_WINDOW) ? MAX_WINDOW : window_len);
      for (int a = 0; a < NumAxes; a++) axis_sum[a] = 0;
      for (int i = 0; i < n; i++) begin
        k = (next_slot + MAX_WINDOW - i) % MAX_WINDOW;
        for (int a = 0; a < NumAxes; a++) begin
          axis_sum[a] += longint'(signed'(history[k][a]));
        end
      end
      for (int a = 0; a < NumAxes; a++) begin
        mean = axis_sum[a] / longint'(n);
        result[a] = mean[POS_WIDTH-1:0];
      end
      next_slot = (next_slot + 1) % MAX_WINDOW;
    end else if (!pause) begin
      // A refill writes every entry, so a later, wider window only sees this position.
      for (int i = 0; i < MAX_WINDOW; i++) history[i] = pos;
      next_slot = 0;
      history_primed = 1'b1;
    end
    smoothed_queue.push_back(result);
  endtask

  task automatic check_word(input position_t actual);
    position_t predicted;
    if (smoothed_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("%0t: result (%0d, %0d, %0d) arrived with none outstanding", $time,
                 signed'(actual[0]), signed'(actual[1]), signed'(actual[2]));
      end
    end else begin
      predicted = smoothed_queue.pop_front();
      for (int a = 0; a < NumAxes; a++) begin
        if (actual[a] !== predicted[a]) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("%0t: avg_%s mismatch, expected %0d, actual %0d", $time,
                     (a == 0) ? "x" : ((a == 1) ? "y" : "z"),
                     signed'(predicted[a]), signed'(actual[a]));
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_queue.delete();
      next_slot = 0;
      history_primed = 1'b0;
      window_len = WindowReset;
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word({avg_z_i, avg_y_i, avg_x_i});
      if (in_valid_i && !in_stall_i) begin
        smooth_word({pos_z_i, pos_y_i, pos_x_i}, paused_i, restart_i);
      end
      if (cfg_wr_en_i) window_len = cfg_wr_data_i;
      fail_count_o <= fail_count;
      pending_o <= smoothed_queue.size();
    end
  end

endmodule

/* dv/position_moving_average_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the position moving average unit: drives directed and random
// positions over a range of window lengths and idling patterns, and gives the verdict.
// Depends on pma_pkg, the unit and position_moving_average_unit_checker.
module position_moving_average_unit_tb;
  import pma_pkg::*;

  localparam int unsigned PosW          = PosWidthDef;
  localparam int unsigned NumPhases     = 16;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = MaxWindowDef + PosWidthDef + 2 * WinW + 8;
  localparam logic [PosW-1:0] PosMax = {1'b0, {(PosW - 1){1'b1}}};
  localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW - 1){1'b0}}};
  localparam logic [NumPhases-1:0][WinW-1:0] WindowPlan = {
    8'd6, 8'd255, 8'd32, 8'd1, 8'd4, 8'd7, 8'd128, 8'd5,
    8'd254, 8'd16, 8'd8, 8'd3, 8'd2, 8'd0, 8'd255, 8'd1
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_wr_en_i = 1'b0;
  logic [WinW-1:0] cfg_wr_data_i = WindowReset;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [PosW-1:0] pos_x_i = '0;
  logic [PosW-1:0] pos_y_i = '0;
  logic [PosW-1:0] pos_z_i = '0;
  logic            paused_i = 1'b0;
  logic            restart_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [PosW-1:0] avg_x_o;
  logic [PosW-1:0] avg_y_o;
  logic [PosW-1:0] avg_z_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  position_moving_average_unit DUT (
    .clk_i,
    .rst_ni,
    .cfg_wr_en_i,
    .cfg_wr_data_i,
    .in_valid_i,
    .in_stall_o,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .paused_i,
    .restart_i,
    .out_valid_o,
    .out_stall_i,
    .avg_x_o,
    .avg_y_o,
    .avg_z_o
  );

  position_moving_average_unit_checker scoreboard (
    .clk_i,
    .rst_ni,
    .cfg_wr_en_i,
    .cfg_wr_data_i,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .paused_i,
    .restart_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .avg_x_i      (avg_x_o),
    .avg_y_i      (avg_y_o),
    .avg_z_i      (avg_z_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic [PosW-1:0] x, input logic [PosW-1:0] y,
                           input logic [PosW-1:0] z, input logic pause, input logic refill);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    paused_i <= pause;
    restart_i <= refill;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [PosW-1:0] random_coord();
    case ($urandom_range(9))
      0: return PosMax;
      1: return PosMin;
      2: return $urandom_range(2) - 1;
      3, 4, 5: return $urandom();
      default: return $urandom_range(2 ** 21) - 2 ** 20;
    endcase
  endfunction

  initial begin
    int unsigned kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset window length of four applies to the directed words.
    send_word(PosMax, PosMin, 1, 1'b1, 1'b0);
    send_word(5, -5, 0, 1'b1, 1'b1);
    send_word(PosMin, PosMax, -1, 1'b0, 1'b0);
    send_word(PosMax, PosMin, 0, 1'b0, 1'b0);
    send_word(PosMax, PosMin, 0, 1'b0, 1'b0);
    send_word(PosMax, PosMin, 0, 1'b0, 1'b0);
    send_word(PosMax, PosMin, 0, 1'b0, 1'b0);
    send_word(0, 0, 0, 1'b1, 1'b0);
    send_word(1, 2, 3, 1'b1, 1'b1);
    send_word(-1, 1, -3, 1'b0, 1'b0);
    send_word(-1, -1, -1, 1'b0, 1'b1);
    send_word(0, 0, 0, 1'b0, 1'b0);
    send_word(0, 0, 0, 1'b0, 1'b0);
    send_word(2, -2, 5, 1'b0, 1'b0);
    send_word(PosMin, PosMin, PosMin, 1'b0, 1'b1);
    send_word(PosMin, PosMin, PosMin, 1'b0, 1'b0);
    send_word(PosMax, PosMax, PosMax, 1'b0, 1'b1);
    send_word(PosMax, PosMax, PosMax, 1'b0, 1'b0);
    send_word(1, -1, 0, 1'b0, 1'b0);
    in_valid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      cfg_wr_en_i <= 1'b1;
      cfg_wr_data_i <= WindowPlan[p];
      @(posedge clk_i);
      cfg_wr_en_i <= 1'b0;
      sender_idle_pct = (p % 4 == 1) ? 63 : ((p % 4 == 3) ? 34 : 0);
      stall_pct <= (p % 4 == 2) ? 63 : ((p % 4 == 3) ? 34 : 0);
      repeat ((WindowPlan[p] >= 64) ? 25 : 145) begin
        kind = $urandom_range(99);
        send_word(random_coord(), random_coord(), random_coord(), kind < 7,
                  kind >= 5 && kind < 12);
      end
      in_valid_i <= 1'b0;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
